// ----- sv/pdl_pkg.sv -----
package pdl_pkg;

  localparam int RES_MAX = 6;
  localparam int RES_CNT_W = 3;
  localparam int POLL_W = 18;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MAX_CLAIM_BYTES = 7'd64;

  localparam logic [1:0] REQ_OPEN = 2'd0;
  localparam logic [1:0] REQ_SEND = 2'd1;
  localparam logic [1:0] REQ_CLAIM = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_CONTROL = 2'd1;
  localparam logic [1:0] KIND_RECV = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [1:0] STAGE_READY = 2'd0;
  localparam logic [1:0] STAGE_CLAIM = 2'd1;
  localparam logic [1:0] STAGE_HANDSHAKE = 2'd2;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_READY = 4'd1;
  localparam logic [3:0] PH_CLAIM = 4'd2;
  localparam logic [3:0] PH_HANDSHAKE = 4'd3;
  localparam logic [3:0] PH_BITS = 4'd4;

  localparam logic CFG_NONCE = 1'b0;
  localparam logic CFG_POLL_LIMIT = 1'b1;

  localparam logic [7:0] KEY_MASK = 8'hD3;
  localparam logic [7:0] TRAIL_CMD = 8'hD0;
  localparam logic [7:0] TRAIL_DATA = 8'hDF;
  localparam logic [7:0] BIT_STROBE = 8'hCF;
  localparam logic [7:0] BIT_RELEASE = 8'hFF;
  localparam logic [7:0] LINK_CLOSE = 8'hBF;
  localparam logic [7:0] OPEN_SYNC = 8'h55;
  localparam logic [7:0] OPEN_CTRL = 8'h04;
  localparam logic [7:0] OPEN_MID = 8'h7F;
  localparam logic [3:0] NIB_HOLD = 4'hF;
  localparam logic [3:0] NIB_LO_STROBE = 4'hC;
  localparam logic [3:0] NIB_HI_SET = 4'h9;
  localparam logic [3:0] NIB_HI_STROBE = 4'h8;
  localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 18'd200000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] port_value;
    logic [7:0] recv_byte;
    logic [1:0] fail_stage;
  } res_t;

  function automatic logic [7:0] hs_first(input logic [1:0] s);
    logic [7:0] v;
    case (s)
      2'd0: v = 8'hDF;
      2'd1: v = 8'hBF;
      2'd2: v = 8'h9F;
      2'd3: v = 8'hBF;
      default: v = 8'hDF;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] hs_second(input logic [1:0] s);
    logic [7:0] v;
    case (s)
      2'd0: v = 8'hEF;
      2'd1: v = 8'hCF;
      2'd2: v = 8'hEF;
      2'd3: v = 8'h8F;
      default: v = 8'hEF;
    endcase
    return v;
  endfunction

  function automatic res_t port_write(input logic [1:0] kind, input logic [7:0] v);
    res_t r;
    r = '0;
    r.kind = kind;
    r.port_value = v;
    return r;
  endfunction

endpackage

// ----- sv/parallel_dongle_link_master.sv -----
// host side of a bit-banged parallel-port dongle link
// req channel (req_valid/req_ready): one request per item; req_type selects
//   open transaction, send byte, receive claim or an ack status sample
// res channel (res_valid/res_ready): the port writes, received bytes and
//   timeouts caused by a request, one per cycle while res_ready is high, with last on the final one
// cfg channel (cfg_valid/cfg_ready, always ready): index 0 session nonce,
//   index 1 poll limit; write only while the link is quiet
// a request is decoded in the cycle it is taken and its results (up to six)
//   land in a result queue; the first shows on res the next cycle
// throughput: one request per cycle for requests with no results, otherwise
//   one request per result delivered (six results for a send, five for open);
//   the result queue drain rate sets this figure
// a new request is taken in the cycle the last queued result is taken
// reset returns the link to idle, empties the queue, nonce 0, poll limit
//   200000
// when res_ready is low with results queued, the queue holds and req_ready stays low
module parallel_dongle_link_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        is_command,
  input  logic        send_clear,
  input  logic [6:0]  byte_count,
  input  logic        ack_level,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  kind,
  output logic [7:0]  port_value,
  output logic [7:0]  recv_byte,
  output logic [1:0]  fail_stage,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
);

  logic [7:0] session_nonce;
  logic [pdl_pkg::POLL_W-1:0] poll_limit;

  logic [3:0] link_phase, link_phase_next;
  logic [1:0] handshake_step, handshake_step_next;
  logic [2:0] bit_index, bit_index_next;
  logic [pdl_pkg::CNT_W-1:0] bytes_left, bytes_left_next;
  logic [7:0] bit_shift, bit_shift_next;
  logic [pdl_pkg::POLL_W-1:0] poll_count, poll_count_next;

  pdl_pkg::res_t res_q [pdl_pkg::RES_MAX];
  pdl_pkg::res_t res_new [pdl_pkg::RES_MAX];
  logic [pdl_pkg::RES_CNT_W-1:0] pend;
  logic [pdl_pkg::RES_CNT_W-1:0] n_new;

  logic req_take, res_take;
  logic [7:0] key, send_b, shift_in;
  logic [pdl_pkg::POLL_W-1:0] lim, poll_inc;
  logic poll_timeout, want;
  logic [7:0] hs_want_byte;
  logic [1:0] hs_next_step;
  logic [pdl_pkg::CNT_W-1:0] bytes_dec;

  assign cfg_ready = 1'b1;
  assign res_valid = (pend != '0);
  assign res_take = res_valid && res_ready;
  assign req_ready = (pend == '0) || ((pend == 3'd1) && res_ready);
  assign req_take = req_valid && req_ready;

  assign kind = res_q[0].kind;
  assign port_value = res_q[0].port_value;
  assign recv_byte = res_q[0].recv_byte;
  assign fail_stage = res_q[0].fail_stage;
  assign last = (pend == 3'd1);

  assign key = session_nonce ^ pdl_pkg::KEY_MASK;
  assign send_b = send_clear ? data_byte : (data_byte ^ key);
  assign lim = (poll_limit == '0) ? {{(pdl_pkg::POLL_W-1){1'b0}}, 1'b1} : poll_limit;
  assign poll_inc = poll_count + 1'b1;
  assign poll_timeout = (poll_inc >= lim);
  assign hs_want_byte = pdl_pkg::hs_second(handshake_step);
  assign want = hs_want_byte[5];
  assign hs_next_step = handshake_step + 2'd1;
  assign shift_in = {bit_shift[6:0], ack_level};
  assign bytes_dec = (bytes_left != '0) ? (bytes_left - 1'b1) : bytes_left;

  always_comb begin
    link_phase_next = link_phase;
    handshake_step_next = handshake_step;
    bit_index_next = bit_index;
    bytes_left_next = bytes_left;
    bit_shift_next = bit_shift;
    poll_count_next = poll_count;
    n_new = '0;
    for (int i = 0; i < pdl_pkg::RES_MAX; i++) begin
      res_new[i] = '0;
    end
    if (req_type == pdl_pkg::REQ_STATUS) begin
      case (link_phase)
        pdl_pkg::PH_READY, pdl_pkg::PH_CLAIM, pdl_pkg::PH_HANDSHAKE: begin
          if ((link_phase == pdl_pkg::PH_READY && ack_level == 1'b1) ||
              (link_phase == pdl_pkg::PH_CLAIM && ack_level == 1'b0) ||
              (link_phase == pdl_pkg::PH_HANDSHAKE && ack_level == want)) begin
            poll_count_next = '0;
            if (link_phase == pdl_pkg::PH_READY) begin
              res_new[0] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::BIT_STROBE);
              n_new = 3'd1;
              link_phase_next = pdl_pkg::PH_CLAIM;
            end else if (link_phase == pdl_pkg::PH_CLAIM) begin
              res_new[0] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::hs_first(2'd0));
              res_new[1] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::hs_second(2'd0));
              n_new = 3'd2;
              handshake_step_next = 2'd0;
              link_phase_next = pdl_pkg::PH_HANDSHAKE;
            end else if (handshake_step != 2'd3) begin
              res_new[0] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                               pdl_pkg::hs_first(hs_next_step));
              res_new[1] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                               pdl_pkg::hs_second(hs_next_step));
              n_new = 3'd2;
              handshake_step_next = hs_next_step;
            end else begin
              handshake_step_next = 2'd0;
              res_new[0] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::TRAIL_DATA);
              n_new = 3'd2;
              if (bytes_left != '0) begin
                res_new[1] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::BIT_STROBE);
                bit_index_next = '0;
                bit_shift_next = '0;
                link_phase_next = pdl_pkg::PH_BITS;
              end else begin
                res_new[1] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::LINK_CLOSE);
                link_phase_next = pdl_pkg::PH_IDLE;
              end
            end
          end else begin
            poll_count_next = poll_inc;
            if (poll_timeout) begin
              res_new[0] = '0;
              res_new[0].kind = pdl_pkg::KIND_TIMEOUT;
              res_new[0].fail_stage = (link_phase == pdl_pkg::PH_READY) ?
                                      pdl_pkg::STAGE_READY :
                                      (link_phase == pdl_pkg::PH_CLAIM) ?
                                      pdl_pkg::STAGE_CLAIM : pdl_pkg::STAGE_HANDSHAKE;
              n_new = 3'd1;
              link_phase_next = pdl_pkg::PH_IDLE;
              poll_count_next = '0;
            end
          end
        end
        pdl_pkg::PH_BITS: begin
          res_new[0] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::BIT_RELEASE);
          if (bit_index != 3'd7) begin
            bit_index_next = bit_index + 3'd1;
            bit_shift_next = shift_in;
            res_new[1] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::BIT_STROBE);
            n_new = 3'd2;
          end else begin
            res_new[1] = '0;
            res_new[1].kind = pdl_pkg::KIND_RECV;
            res_new[1].recv_byte = shift_in ^ key;
            bit_index_next = '0;
            bit_shift_next = '0;
            bytes_left_next = bytes_dec;
            n_new = 3'd3;
            if (bytes_dec != '0) begin
              res_new[2] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::BIT_STROBE);
            end else begin
              res_new[2] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::LINK_CLOSE);
              link_phase_next = pdl_pkg::PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (link_phase == pdl_pkg::PH_IDLE) begin
      case (req_type)
        pdl_pkg::REQ_OPEN: begin
          res_new[0] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::OPEN_SYNC);
          res_new[1] = pdl_pkg::port_write(pdl_pkg::KIND_CONTROL, pdl_pkg::OPEN_CTRL);
          res_new[2] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::LINK_CLOSE);
          res_new[3] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::OPEN_MID);
          res_new[4] = pdl_pkg::port_write(pdl_pkg::KIND_DATA, pdl_pkg::LINK_CLOSE);
          n_new = 3'd5;
        end
        pdl_pkg::REQ_SEND: begin
          res_new[0] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                           {pdl_pkg::NIB_HOLD, send_b[3:0]});
          res_new[1] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                           {pdl_pkg::NIB_LO_STROBE, send_b[3:0]});
          res_new[2] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                           {pdl_pkg::NIB_HOLD, send_b[3:0]});
          res_new[3] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                           {pdl_pkg::NIB_HI_SET, send_b[7:4]});
          res_new[4] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                           {pdl_pkg::NIB_HI_STROBE, send_b[7:4]});
          res_new[5] = pdl_pkg::port_write(pdl_pkg::KIND_DATA,
                                           is_command ? pdl_pkg::TRAIL_CMD :
                                                        pdl_pkg::TRAIL_DATA);
          n_new = 3'd6;
        end
        pdl_pkg::REQ_CLAIM: begin
          bytes_left_next = (byte_count > pdl_pkg::MAX_CLAIM_BYTES) ?
                            pdl_pkg::MAX_CLAIM_BYTES : byte_count;
          handshake_step_next = '0;
          bit_index_next = '0;
          bit_shift_next = '0;
          poll_count_next = '0;
          link_phase_next = pdl_pkg::PH_READY;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_nonce <= '0;
      poll_limit <= pdl_pkg::POLL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pdl_pkg::CFG_NONCE) begin
        session_nonce <= cfg_data[7:0];
      end else begin
        poll_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase <= pdl_pkg::PH_IDLE;
      handshake_step <= '0;
      bit_index <= '0;
      bytes_left <= '0;
      bit_shift <= '0;
      poll_count <= '0;
    end else if (req_take) begin
      link_phase <= link_phase_next;
      handshake_step <= handshake_step_next;
      bit_index <= bit_index_next;
      bytes_left <= bytes_left_next;
      bit_shift <= bit_shift_next;
      poll_count <= poll_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (req_take) begin
      pend <= n_new;
    end else if (res_take) begin
      pend <= pend - 3'd1;
    end
  end

  // result queue, head at entry 0
  always_ff @(posedge clk) begin
    if (req_take) begin
      for (int i = 0; i < pdl_pkg::RES_MAX; i++) begin
        res_q[i] <= res_new[i];
      end
    end else if (res_take) begin
      for (int i = 0; i < pdl_pkg::RES_MAX - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'd6)
    else $error("result queue overrun");

  a_timeout_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == pdl_pkg::KIND_TIMEOUT) |-> last)
    else $error("timeout not final result");

  a_claim_start: assert property (@(posedge clk) disable iff (rst)
    (req_take && req_type == pdl_pkg::REQ_CLAIM && link_phase == pdl_pkg::PH_IDLE)
    |=> (link_phase == pdl_pkg::PH_READY && pend == '0))
    else $error("claim did not start wait");

  a_bits_have_bytes: assert property (@(posedge clk) disable iff (rst)
    (link_phase == pdl_pkg::PH_BITS) |-> (bytes_left != '0))
    else $error("bit reads with no bytes left");

endmodule

// ----- tb/sv/parallel_dongle_link_master_tb.sv -----
`timescale 1ns / 1ps

module parallel_dongle_link_master_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int QUIET_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS = 30;

  typedef struct packed {
    logic [1:0] rtype;
    logic [7:0] data;
    logic       cmd;
    logic       clear;
    logic [6:0] count;
    logic       ack;
  } link_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] port_value;
    logic [7:0] recv_byte;
    logic [1:0] fail_stage;
    logic       last;
  } link_ev_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  req_type = '0;
  logic [7:0]  data_byte = '0;
  logic        is_command = 1'b0;
  logic        send_clear = 1'b0;
  logic [6:0]  byte_count = '0;
  logic        ack_level = 1'b0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  port_value;
  logic [7:0]  recv_byte;
  logic [1:0]  fail_stage;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [17:0] cfg_data = '0;

  parallel_dongle_link_master dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_type(req_type),
    .data_byte(data_byte),
    .is_command(is_command),
    .send_clear(send_clear),
    .byte_count(byte_count),
    .ack_level(ack_level),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .kind(kind),
    .port_value(port_value),
    .recv_byte(recv_byte),
    .fail_stage(fail_stage),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // link state mirror
  logic [7:0]                 nonce_q = '0;
  logic [pdl_pkg::POLL_W-1:0] poll_lim_q = pdl_pkg::POLL_LIMIT_RESET;
  logic [3:0]                 link_phase = pdl_pkg::PH_IDLE;
  logic [1:0]                 hs_step = '0;
  logic [2:0]                 bit_idx = '0;
  logic [6:0]                 bytes_left = '0;
  logic [7:0]                 bit_shift = '0;
  logic [pdl_pkg::POLL_W-1:0] poll_cnt = '0;

  link_ev_t  step_events[$];
  link_ev_t  link_events_due[$];
  link_req_t pending_reqs[$];
  link_req_t drive_req;
  link_req_t seen_req;
  link_ev_t  got_ev;
  link_ev_t  want_ev;

  int mismatches = 0;
  int gen_items = 0;
  int gen_limit = int'(pdl_pkg::POLL_LIMIT_RESET);
  bit want_hold = 1'b0;
  int n_open = 0, n_send = 0, n_claim = 0, n_status = 0;
  int n_checked = 0, n_recv = 0, n_timeout = 0;
  int unsigned cycle_count = 0;

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] hs_byte(input logic [1:0] step, input logic second);
    logic [7:0] v;
    case ({step, second})
      3'b000: v = 8'hDF;
      3'b001: v = 8'hEF;
      3'b010: v = 8'hBF;
      3'b011: v = 8'hCF;
      3'b100: v = 8'h9F;
      3'b101: v = 8'hEF;
      3'b110: v = 8'hBF;
      default: v = 8'h8F;
    endcase
    return v;
  endfunction

  function automatic void emit_ev(input logic [1:0] k, input logic [7:0] pv,
                                  input logic [7:0] rb, input logic [1:0] st);
    link_ev_t e;
    e.kind = k;
    e.port_value = pv;
    e.recv_byte = rb;
    e.fail_stage = st;
    e.last = 1'b0;
    step_events.push_back(e);
  endfunction

  function automatic void emit_write(input logic [7:0] pv);
    emit_ev(pdl_pkg::KIND_DATA, pv, '0, '0);
  endfunction

  function automatic logic ack_matches(input logic lvl, input logic want,
                                       input logic [1:0] stage);
    logic [pdl_pkg::POLL_W-1:0] lim;
    logic ok;
    lim = (poll_lim_q == '0) ? 18'd1 : poll_lim_q;
    ok = (lvl == want);
    if (ok) begin
      poll_cnt = '0;
    end else begin
      poll_cnt = poll_cnt + 1'b1;
      if (poll_cnt >= lim) begin
        emit_ev(pdl_pkg::KIND_TIMEOUT, '0, '0, stage);
        link_phase = pdl_pkg::PH_IDLE;
        poll_cnt = '0;
      end
    end
    return ok;
  endfunction

  function automatic void take_sample(input logic lvl);
    logic [1:0] s;
    logic [7:0] pair_hi;
    s = hs_step;
    pair_hi = hs_byte(s, 1'b1);
    case (link_phase)
      pdl_pkg::PH_READY: begin
        if (ack_matches(lvl, 1'b1, pdl_pkg::STAGE_READY)) begin
          emit_write(pdl_pkg::BIT_STROBE);
          link_phase = pdl_pkg::PH_CLAIM;
        end
      end
      pdl_pkg::PH_CLAIM: begin
        if (ack_matches(lvl, 1'b0, pdl_pkg::STAGE_CLAIM)) begin
          emit_write(hs_byte(2'd0, 1'b0));
          emit_write(hs_byte(2'd0, 1'b1));
          hs_step = '0;
          link_phase = pdl_pkg::PH_HANDSHAKE;
        end
      end
      pdl_pkg::PH_HANDSHAKE: begin
        if (ack_matches(lvl, pair_hi[5], pdl_pkg::STAGE_HANDSHAKE)) begin
          if (s != 2'd3) begin
            hs_step = s + 1'b1;
            emit_write(hs_byte(hs_step, 1'b0));
            emit_write(hs_byte(hs_step, 1'b1));
          end else begin
            hs_step = '0;
            emit_write(pdl_pkg::TRAIL_DATA);
            if (bytes_left != '0) begin
              emit_write(pdl_pkg::BIT_STROBE);
              bit_idx = '0;
              bit_shift = '0;
              link_phase = pdl_pkg::PH_BITS;
            end else begin
              emit_write(pdl_pkg::LINK_CLOSE);
              link_phase = pdl_pkg::PH_IDLE;
            end
          end
        end
      end
      pdl_pkg::PH_BITS: begin
        bit_shift = {bit_shift[6:0], lvl};
        emit_write(pdl_pkg::BIT_RELEASE);
        if (bit_idx != 3'd7) begin
          bit_idx = bit_idx + 1'b1;
          emit_write(pdl_pkg::BIT_STROBE);
        end else begin
          emit_ev(pdl_pkg::KIND_RECV, '0, bit_shift ^ nonce_q ^ pdl_pkg::KEY_MASK, '0);
          bit_idx = '0;
          bit_shift = '0;
          if (bytes_left != '0)
            bytes_left = bytes_left - 1'b1;
          if (bytes_left != '0) begin
            emit_write(pdl_pkg::BIT_STROBE);
          end else begin
            emit_write(pdl_pkg::LINK_CLOSE);
            link_phase = pdl_pkg::PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void link_model_step(input link_req_t q);
    logic [7:0] b;
    link_ev_t tail;
    int i;
    step_events.delete();
    if (q.rtype == pdl_pkg::REQ_STATUS) begin
      take_sample(q.ack);
    end else if (link_phase == pdl_pkg::PH_IDLE) begin
      case (q.rtype)
        pdl_pkg::REQ_OPEN: begin
          emit_write(pdl_pkg::OPEN_SYNC);
          emit_ev(pdl_pkg::KIND_CONTROL, pdl_pkg::OPEN_CTRL, '0, '0);
          emit_write(pdl_pkg::LINK_CLOSE);
          emit_write(pdl_pkg::OPEN_MID);
          emit_write(pdl_pkg::LINK_CLOSE);
        end
        pdl_pkg::REQ_SEND: begin
          b = q.clear ? q.data : (q.data ^ nonce_q ^ pdl_pkg::KEY_MASK);
          emit_write({pdl_pkg::NIB_HOLD, b[3:0]});
          emit_write({pdl_pkg::NIB_LO_STROBE, b[3:0]});
          emit_write({pdl_pkg::NIB_HOLD, b[3:0]});
          emit_write({pdl_pkg::NIB_HI_SET, b[7:4]});
          emit_write({pdl_pkg::NIB_HI_STROBE, b[7:4]});
          emit_write(q.cmd ? pdl_pkg::TRAIL_CMD : pdl_pkg::TRAIL_DATA);
        end
        default: begin
          bytes_left = (q.count > pdl_pkg::MAX_CLAIM_BYTES) ?
                       pdl_pkg::MAX_CLAIM_BYTES : q.count;
          hs_step = '0;
          bit_idx = '0;
          bit_shift = '0;
          poll_cnt = '0;
          link_phase = pdl_pkg::PH_READY;
        end
      endcase
    end
    if (step_events.size() != 0) begin
      tail = step_events.pop_back();
      tail.last = 1'b1;
      step_events.push_back(tail);
    end
    for (i = 0; i < step_events.size(); i++)
      link_events_due.push_back(step_events[i]);
  endfunction

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!req_valid || req_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        drive_req = pending_reqs.pop_front();
        req_type <= drive_req.rtype;
        data_byte <= drive_req.data;
        is_command <= drive_req.cmd;
        send_clear <= drive_req.clear;
        byte_count <= drive_req.count;
        ack_level <= drive_req.ack;
        req_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern per epoch, plus one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  epoch_left = 0;
  int  stall_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold_left <= 0;
      epoch_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (want_hold && !hold_done && res_valid && req_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      res_ready <= 1'b0;
    end else begin
      if (epoch_left == 0) begin
        epoch_left <= $urandom_range(20, 80);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        epoch_left <= epoch_left - 1;
      end
      case (stall_mode)
        0: res_ready <= 1'b1;
        1: res_ready <= 1'($urandom_range(0, 1));
        2: res_ready <= ($urandom_range(0, 3) == 0);
        default: res_ready <= (epoch_left[2:0] != 3'd0);
      endcase
    end
  end

  // monitor: check results, track register writes, predict accepted requests
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        got_ev = '{kind, port_value, recv_byte, fail_stage, last};
        if (link_events_due.size() == 0) begin
          flag_mismatch($sformatf(
            "unexpected result kind %0d port %h recv %h stage %0d last %0b",
            kind, port_value, recv_byte, fail_stage, last));
        end else begin
          want_ev = link_events_due.pop_front();
          n_checked++;
          if (want_ev.kind == pdl_pkg::KIND_RECV) n_recv++;
          if (want_ev.kind == pdl_pkg::KIND_TIMEOUT) n_timeout++;
          if (got_ev !== want_ev)
            flag_mismatch($sformatf(
              "result kind %0d/%0d port %h/%h recv %h/%h stage %0d/%0d last %0b/%0b (got/exp)",
              got_ev.kind, want_ev.kind, got_ev.port_value, want_ev.port_value,
              got_ev.recv_byte, want_ev.recv_byte, got_ev.fail_stage, want_ev.fail_stage,
              got_ev.last, want_ev.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pdl_pkg::CFG_NONCE)
          nonce_q = cfg_data[7:0];
        else
          poll_lim_q = cfg_data;
      end
      if (req_valid && req_ready) begin
        seen_req = '{req_type, data_byte, is_command, send_clear, byte_count, ack_level};
        case (req_type)
          pdl_pkg::REQ_OPEN: n_open++;
          pdl_pkg::REQ_SEND: n_send++;
          pdl_pkg::REQ_CLAIM: n_claim++;
          default: n_status++;
        endcase
        link_model_step(seen_req);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [17:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pdl_pkg::CFG_POLL_LIMIT)
      gen_limit = int'(val);
  endtask

  task automatic queue_req(input logic [1:0] rt, input logic [7:0] d, input logic c,
                           input logic clr, input logic [6:0] cnt, input logic a);
    link_req_t r;
    r = '{rt, d, c, clr, cnt, a};
    pending_reqs.push_back(r);
    gen_items++;
  endtask

  task automatic queue_sample(input logic lvl);
    queue_req(pdl_pkg::REQ_STATUS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), lvl);
  endtask

  // request that a claim in progress must ignore
  task automatic queue_junk();
    queue_req(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endtask

  // break_at: -1 completes, 0 ready, 1 claim, 2..5 handshake steps
  task automatic queue_claim(input int cnt, input int break_at, input bit noisy);
    int lim, st, n_wrong, nbits;
    logic want;
    logic [7:0] pair_hi;
    lim = (gen_limit == 0) ? 1 : gen_limit;
    queue_req(pdl_pkg::REQ_CLAIM, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 7'(cnt), 1'($urandom_range(0, 1)));
    for (st = 0; st < 6; st++) begin
      if (st == 0) begin
        want = 1'b1;
      end else if (st == 1) begin
        want = 1'b0;
      end else begin
        pair_hi = hs_byte(2'(st - 2), 1'b1);
        want = pair_hi[5];
      end
      if (noisy)
        queue_junk();
      if (st == break_at) begin
        repeat (lim) queue_sample(!want);
        return;
      end
      n_wrong = (lim > 1) ? $urandom_range(0, (lim > 4) ? 3 : lim - 1) : 0;
      repeat (n_wrong) queue_sample(!want);
      queue_sample(want);
    end
    nbits = 8 * ((cnt > int'(pdl_pkg::MAX_CLAIM_BYTES)) ? int'(pdl_pkg::MAX_CLAIM_BYTES) : cnt);
    repeat (nbits) queue_sample(1'($urandom_range(0, 1)));
  endtask

  task automatic queue_random_item();
    int pick, lim, brk, cnt, sz;
    lim = (gen_limit == 0) ? 1 : gen_limit;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      queue_req(pdl_pkg::REQ_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                1'($urandom_range(0, 1)));
    end else if (pick < 50) begin
      queue_req(pdl_pkg::REQ_OPEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                1'($urandom_range(0, 1)));
    end else if (pick < 85) begin
      sz = $urandom_range(0, 9);
      if (sz == 0) cnt = 0;
      else if (sz < 8) cnt = 1;
      else if (sz == 8) cnt = $urandom_range(2, 4);
      else cnt = $urandom_range(5, 8);
      brk = (lim <= 6 && $urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1;
      queue_claim(cnt, brk, $urandom_range(0, 9) == 0);
    end else begin
      queue_sample(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic queue_random_run(input int n);
    int goal;
    goal = gen_items + n;
    while (gen_items < goal) queue_random_item();
  endtask

  function automatic logic drain_level();
    logic [7:0] pair_hi;
    pair_hi = hs_byte(hs_step, 1'b1);
    case (link_phase)
      pdl_pkg::PH_READY: return 1'b1;
      pdl_pkg::PH_CLAIM: return 1'b0;
      pdl_pkg::PH_HANDSHAKE: return pair_hi[5];
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // wait for all requests and results, finish any open claim, then let the link go quiet
  task automatic settle_link();
    while (pending_reqs.size() != 0 || req_valid || link_events_due.size() != 0)
      @(negedge clk);
    while (link_phase != pdl_pkg::PH_IDLE) begin
      queue_sample(drain_level());
      @(negedge clk);
      while (pending_reqs.size() != 0 || req_valid || link_events_due.size() != 0)
        @(negedge clk);
    end
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_reg(pdl_pkg::CFG_NONCE, 18'h000A5);
    write_reg(pdl_pkg::CFG_POLL_LIMIT, 18'd3);
    queue_req(pdl_pkg::REQ_OPEN, 8'h00, 1'b0, 1'b0, 7'd0, 1'b0);
    queue_req(pdl_pkg::REQ_SEND, 8'h00, 1'b1, 1'b0, 7'd0, 1'b0);
    queue_req(pdl_pkg::REQ_SEND, 8'hFF, 1'b0, 1'b1, 7'h7F, 1'b1);
    queue_req(pdl_pkg::REQ_SEND, 8'h5A, 1'b1, 1'b1, 7'd1, 1'b0);
    queue_req(pdl_pkg::REQ_SEND, 8'hA5, 1'b0, 1'b0, 7'd64, 1'b1);
    queue_req(pdl_pkg::REQ_STATUS, 8'h00, 1'b0, 1'b0, 7'd0, 1'b0);
    queue_req(pdl_pkg::REQ_STATUS, 8'hFF, 1'b1, 1'b1, 7'h7F, 1'b1);
    queue_claim(0, -1, 1'b0);
    queue_claim(1, -1, 1'b1);
    queue_claim(1, 0, 1'b0);
    queue_claim(1, 2, 1'b0);
    queue_claim(127, 5, 1'b0);
    queue_req(pdl_pkg::REQ_OPEN, 8'hFF, 1'b1, 1'b1, 7'h7F, 1'b1);
    settle_link();

    // zero poll limit: first wrong sample times out
    write_reg(pdl_pkg::CFG_POLL_LIMIT, 18'd0);
    write_reg(pdl_pkg::CFG_NONCE, 18'h000FF);
    queue_claim(1, 0, 1'b0);
    queue_claim(1, 3, 1'b0);
    queue_claim(1, -1, 1'b0);
    queue_random_run(10);
    settle_link();

    write_reg(pdl_pkg::CFG_NONCE, 18'h00000);
    write_reg(pdl_pkg::CFG_POLL_LIMIT, 18'h3FFFF);
    want_hold = 1'b1;
    queue_req(pdl_pkg::REQ_SEND, 8'h3C, 1'b0, 1'b0, 7'd0, 1'b0);
    queue_req(pdl_pkg::REQ_SEND, 8'hC3, 1'b1, 1'b0, 7'd0, 1'b0);
    queue_random_run(10);
    settle_link();

    write_reg(pdl_pkg::CFG_NONCE, 18'($urandom_range(0, 255)));
    write_reg(pdl_pkg::CFG_POLL_LIMIT, 18'd2);
    queue_random_run(15);
    settle_link();

    if (link_events_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", link_events_due.size()));
    $display("requests taken: %0d open, %0d send, %0d claim, %0d status samples",
             n_open, n_send, n_claim, n_status);
    $display("results checked: %0d, of which %0d received bytes and %0d timeouts",
             n_checked, n_recv, n_timeout);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
